>>> design/ucep_pkg.sv
// ucep_pkg: shared types, request codes and descriptor tables of the
// control endpoint handler. No dependencies.
`default_nettype none
package ucep_pkg;

	// event codes on the cmd field
	localparam logic [1:0] CMD_SETUP    = 2'd0;
	localparam logic [1:0] CMD_IN_DONE  = 2'd1;
	localparam logic [1:0] CMD_OUT_DONE = 2'd2;
	localparam logic [1:0] CMD_BUS_RST  = 2'd3;

	// handshake codes
	localparam logic [1:0] HS_ACK   = 2'd0;
	localparam logic [1:0] HS_STALL = 2'd1;
	localparam logic [1:0] HS_IDLE  = 2'd2;

	// register indexes on the config port
	localparam logic REG_DEVICE_SERIAL  = 1'b0;
	localparam logic REG_DEVICE_VERSION = 1'b1;

	// bmRequestType fields
	localparam logic [7:0] RT_TYPE_MASK  = 8'h60;
	localparam logic [7:0] RT_TYPE_CLASS = 8'h20;
	localparam logic [7:0] RT_TYPE_STD   = 8'h00;
	localparam logic [7:0] RT_RCPT_MASK  = 8'h1F;
	localparam logic [7:0] RT_RCPT_EP    = 8'h02;

	// standard and class request codes
	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
	localparam logic [7:0] REQ_SET_DEV_ADDR      = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0A;
	localparam logic [7:0] HID_SET_IDLE          = 8'h0A;

	// descriptor types
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	// string indexes
	localparam logic [7:0] STRIDX_LANGID = 8'd0;
	localparam logic [7:0] STR_NAME      = 8'd2;
	localparam logic [7:0] STRIDX_SERNUM = 8'd3;

	// endpoint addresses
	localparam logic [7:0] EP1_IN  = 8'h81;
	localparam logic [7:0] EP1_OUT = 8'h01;

	// descriptor lengths
	localparam logic [5:0] LEN_DEVICE = 6'd18;
	localparam logic [5:0] LEN_CONFIG = 6'd41;
	localparam logic [5:0] LEN_REPORT = 6'd25;
	localparam logic [5:0] LEN_LANG   = 6'd4;
	localparam logic [5:0] LEN_SERIAL = 6'd34;
	localparam logic [5:0] LEN_NAME   = 6'd18;

	typedef enum logic [2:0] {
		SRC_ZERO,
		SRC_DEVICE,
		SRC_CONFIG,
		SRC_REPORT,
		SRC_LANG,
		SRC_SERIAL,
		SRC_NAME,
		SRC_CFG_VAL
	} src_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} state_t;

	// decoded setup packet
	typedef struct packed {
		logic       err;
		src_t       src;
		logic [5:0] raw_len;
		logic       ein;
		logic       eout;
		logic       set_addr;
		logic       set_cfg;
	} dec_t;

	// device descriptor, packet size and bcdDevice bytes patched by the ROM
	function automatic logic [7:0] tab_device(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:    b = 8'd18;
			6'd1:    b = 8'h01;
			6'd2:    b = 8'h10;
			6'd3:    b = 8'h01;
			6'd8:    b = 8'h09;
			6'd9:    b = 8'h12;
			6'd10:   b = 8'h01;
			6'd14:   b = 8'd1;
			6'd15:   b = 8'd2;
			6'd16:   b = 8'd3;
			6'd17:   b = 8'd1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] tab_config(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:    b = 8'd9;
			6'd1:    b = 8'h02;
			6'd2:    b = 8'd41;
			6'd4:    b = 8'd1;
			6'd5:    b = 8'd1;
			6'd7:    b = 8'h80;
			6'd8:    b = 8'd50;
			6'd9:    b = 8'd9;
			6'd10:   b = 8'h04;
			6'd13:   b = 8'd2;
			6'd14:   b = 8'h03;
			6'd18:   b = 8'd9;
			6'd19:   b = 8'h21;
			6'd20:   b = 8'h11;
			6'd21:   b = 8'h01;
			6'd23:   b = 8'd1;
			6'd24:   b = 8'h22;
			6'd25:   b = 8'd25;
			6'd27:   b = 8'd7;
			6'd28:   b = 8'h05;
			6'd29:   b = 8'h01;
			6'd30:   b = 8'h03;
			6'd31:   b = 8'h40;
			6'd33:   b = 8'd1;
			6'd34:   b = 8'd7;
			6'd35:   b = 8'h05;
			6'd36:   b = 8'h81;
			6'd37:   b = 8'h03;
			6'd38:   b = 8'h40;
			6'd40:   b = 8'd1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] tab_report(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:    b = 8'h06;
			6'd2:    b = 8'hFF;
			6'd3:    b = 8'h09;
			6'd4:    b = 8'h01;
			6'd5:    b = 8'hA1;
			6'd6:    b = 8'h01;
			6'd7:    b = 8'h15;
			6'd9:    b = 8'h26;
			6'd10:   b = 8'hFF;
			6'd12:   b = 8'h75;
			6'd13:   b = 8'h08;
			6'd14:   b = 8'h95;
			6'd15:   b = 8'h40;
			6'd16:   b = 8'h09;
			6'd17:   b = 8'h01;
			6'd18:   b = 8'h81;
			6'd19:   b = 8'h02;
			6'd20:   b = 8'h09;
			6'd21:   b = 8'h01;
			6'd22:   b = 8'h91;
			6'd23:   b = 8'h02;
			6'd24:   b = 8'hC0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] tab_lang(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:    b = 8'd4;
			6'd1:    b = 8'h03;
			6'd2:    b = 8'h09;
			6'd3:    b = 8'h04;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// product name string, UTF-16LE
	function automatic logic [7:0] tab_name(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:    b = 8'd18;
			6'd1:    b = 8'h03;
			6'd2:    b = 8'h4F;
			6'd4:    b = 8'h70;
			6'd6:    b = 8'h65;
			6'd8:    b = 8'h6E;
			6'd10:   b = 8'h42;
			6'd12:   b = 8'h6F;
			6'd14:   b = 8'h6F;
			6'd16:   b = 8'h74;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// uppercase ASCII hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] b;
		if (v < 4'd10) begin
			b = 8'h30 + {4'd0, v};
		end else begin
			b = 8'h37 + {4'd0, v};
		end
		return b;
	endfunction

endpackage
`default_nettype wire

>>> design/ucep_decode.sv
// ucep_decode: setup packet decoder, turns the request fields into a
// descriptor source, a raw length and side effects. Uses ucep_pkg.
`default_nettype none
module ucep_decode (
	input  wire logic [7:0]   request_type,
	input  wire logic [7:0]   request_code,
	input  wire logic [7:0]   value_low,
	input  wire logic [7:0]   value_high,
	input  wire logic [7:0]   index_low,
	output ucep_pkg::dec_t    dec
);
	import ucep_pkg::*;

	always_comb begin
		dec = '0;
		dec.src = SRC_ZERO;
		if ((request_type & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
			// only SET_IDLE is supported among class requests
			dec.err = (request_code != HID_SET_IDLE);
		end else if ((request_type & RT_TYPE_MASK) != RT_TYPE_STD) begin
			dec.err = 1'b1;
		end else begin
			case (request_code)
				REQ_GET_DESCRIPTOR: begin
					case (value_high)
						DESC_DEVICE: begin
							dec.src = SRC_DEVICE;
							dec.raw_len = LEN_DEVICE;
						end
						DESC_CONFIG: begin
							dec.src = SRC_CONFIG;
							dec.raw_len = LEN_CONFIG;
						end
						DESC_REPORT: begin
							dec.src = SRC_REPORT;
							dec.raw_len = LEN_REPORT;
						end
						DESC_STRING: begin
							if (value_low == STRIDX_LANGID) begin
								dec.src = SRC_LANG;
								dec.raw_len = LEN_LANG;
							end else if (value_low == STRIDX_SERNUM) begin
								dec.src = SRC_SERIAL;
								dec.raw_len = LEN_SERIAL;
							end else if (value_low <= STR_NAME) begin
								dec.src = SRC_NAME;
								dec.raw_len = LEN_NAME;
							end else begin
								dec.err = 1'b1;
							end
						end
						default: dec.err = 1'b1;
					endcase
				end
				REQ_SET_DEV_ADDR:      dec.set_addr = 1'b1;
				REQ_GET_CONFIGURATION: begin
					dec.src = SRC_CFG_VAL;
					dec.raw_len = 6'd1;
				end
				REQ_SET_CONFIGURATION: dec.set_cfg = 1'b1;
				REQ_GET_INTERFACE:     dec.raw_len = 6'd1;
				REQ_GET_STATUS:        dec.raw_len = 6'd2;
				REQ_CLEAR_FEATURE: begin
					// non-endpoint recipients: ack, no effect
					if ((request_type & RT_RCPT_MASK) == RT_RCPT_EP) begin
						if (index_low == EP1_IN) begin
							dec.ein = 1'b1;
						end else if (index_low == EP1_OUT) begin
							dec.eout = 1'b1;
						end else begin
							dec.err = 1'b1;
						end
					end
				end
				REQ_SET_FEATURE: dec.err = 1'b0;
				default:         dec.err = 1'b1;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/ucep_rom.sv
// ucep_rom: byte source shared by all data stages; fixed tables, patched
// device fields and the hex serial string. Uses ucep_pkg.
`default_nettype none
module ucep_rom #(
	parameter int MAX_PACKET = 64
) (
	input  wire ucep_pkg::src_t src,
	input  wire logic [5:0]     idx,
	input  wire logic [63:0]    device_serial,
	input  wire logic [15:0]    device_version,
	input  wire logic [7:0]     configuration,
	output logic [7:0]          data
);
	import ucep_pkg::*;

	logic [3:0] digit;   // serial character number, msn first
	logic [3:0] nib_sel;
	logic [3:0] nibble;

	assign digit   = idx[4:1] - 4'd1;
	assign nib_sel = 4'd15 - digit;
	assign nibble  = device_serial[{nib_sel, 2'b00} +: 4];

	always_comb begin
		case (src)
			SRC_DEVICE: begin
				case (idx)
					6'd7:    data = 8'(MAX_PACKET);
					6'd12:   data = device_version[7:0];
					6'd13:   data = device_version[15:8];
					default: data = tab_device(idx);
				endcase
			end
			SRC_CONFIG: data = tab_config(idx);
			SRC_REPORT: data = tab_report(idx);
			SRC_LANG:   data = tab_lang(idx);
			SRC_NAME:   data = tab_name(idx);
			SRC_SERIAL: begin
				if (idx == 6'd0) begin
					data = {2'b00, LEN_SERIAL};
				end else if (idx == 6'd1) begin
					data = DESC_STRING;
				end else if (!idx[0]) begin
					data = hex_char(nibble);
				end else begin
					data = 8'h00;
				end
			end
			SRC_CFG_VAL: data = (idx == 6'd0) ? configuration : 8'h00;
			default:     data = 8'h00;
		endcase
	end

endmodule
`default_nettype wire

>>> design/usb_control_endpoint_handler_unit.sv
// usb_control_endpoint_handler_unit: EP0 request handler top level with
// sequencer, state registers and result register. Uses ucep_pkg,
// ucep_decode and ucep_rom.
`default_nettype none
// One event beat is taken on req_valid/req_ready and produces one or more
// result beats on res_valid/res_ready. A setup packet is decoded in the
// cycle after it is taken; then a small sequencer steps one byte index per
// cycle (held while a result waits on res_ready) through the shared
// descriptor ROM (ucep_rom), so a data stage of N bytes (N clipped to
// wLength and to MAX_PACKET, at most 41 for the largest descriptor) gives
// N result beats; every other event (stall, status only, IN/OUT done, bus
// reset) gives a single result. req_ready is high only while the sequencer
// is idle; the last result of an event sits in the output register, so the
// next event is taken while that beat still waits for the sink. Every
// result carries the bus address and configuration as they stand after
// the event. The SET_ADDRESS value is latched into the bus address when
// the following IN-done event arrives. Configuration writes on cfg_we are
// taken in any cycle and are meant for idle periods only.
module usb_control_endpoint_handler_unit #(
	parameter int MAX_PACKET = 64   // EP0 packet size, 8 to 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	// event beats
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  request_type,
	input  wire logic [7:0]  request_code,
	input  wire logic [7:0]  value_low,
	input  wire logic [7:0]  value_high,
	input  wire logic [7:0]  index_low,
	input  wire logic [15:0] max_length,
	// result beats
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [1:0]       handshake,
	output logic [6:0]       tx_length,
	output logic [7:0]       data_byte,
	output logic             byte_valid,
	output logic             last,
	output logic [6:0]       device_address,
	output logic [7:0]       configuration,
	output logic             ep1_in_halt_clear,
	output logic             ep1_out_halt_clear,
	output logic             ep1_reset
);
	import ucep_pkg::*;

	localparam logic [6:0] MaxLen = 7'(MAX_PACKET);

	state_t state_q, state_d;

	logic [63:0] serial_q;
	logic [15:0] version_q;
	logic [7:0]  last_req_q;
	logic [7:0]  new_addr_q;
	logic [6:0]  bus_addr_q;
	logic [7:0]  cur_cfg_q;

	// captured event
	logic [1:0]  cmd_q;
	logic [7:0]  rt_q, rc_q, vl_q, vh_q, ixl_q;
	logic [15:0] wlen_q;

	// per-event emit context
	logic [1:0]  hs_q;
	logic [6:0]  len_q;
	src_t        src_q;
	logic        ein_q, eout_q, erst_q;
	logic [5:0]  idx_q;

	// emit context as set up by the decode cycle
	logic [1:0]  hs_d;
	logic [6:0]  len_d;
	logic        ein_d, eout_d, erst_d;

	// result register
	logic        res_valid_q;
	logic [1:0]  hs_out_q;
	logic [6:0]  txl_out_q;
	logic [7:0]  byte_out_q;
	logic        bv_out_q, last_out_q, ein_out_q, eout_out_q, erst_out_q;
	logic [6:0]  addr_out_q;
	logic [7:0]  cfg_out_q;

	dec_t        dec;
	logic [7:0]  rom_byte;
	logic [6:0]  clip_len;
	logic        accept, do_decode, load, final_beat;

	ucep_decode u_decode (
		.request_type (rt_q),
		.request_code (rc_q),
		.value_low    (vl_q),
		.value_high   (vh_q),
		.index_low    (ixl_q),
		.dec          (dec)
	);

	ucep_rom #(
		.MAX_PACKET (MAX_PACKET)
	) u_rom (
		.src            (src_q),
		.idx            (idx_q),
		.device_serial  (serial_q),
		.device_version (version_q),
		.configuration  (cur_cfg_q),
		.data           (rom_byte)
	);

	// clip to wLength, then to one packet
	always_comb begin
		clip_len = {1'b0, dec.raw_len};
		if (wlen_q < {10'd0, dec.raw_len}) begin
			clip_len = wlen_q[6:0];
		end
		if (clip_len > MaxLen) begin
			clip_len = MaxLen;
		end
	end

	assign final_beat = (len_q == 7'd0) || ({1'b0, idx_q} + 7'd1 == len_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_DECODE;
			ST_DECODE: state_d = ST_EMIT;
			ST_EMIT:   if (load && final_beat) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		do_decode = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_DECODE: do_decode = 1'b1;
			ST_EMIT:   load = !res_valid_q || res_ready;
			default:   req_ready = 1'b0;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q  <= '0;
			version_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_SERIAL:  serial_q <= cfg_data;
				REG_DEVICE_VERSION: version_q <= cfg_data[15:0];
				default:            serial_q <= serial_q;
			endcase
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			rt_q   <= request_type;
			rc_q   <= request_code;
			vl_q   <= value_low;
			vh_q   <= value_high;
			ixl_q  <= index_low;
			wlen_q <= max_length;
		end
	end

	// device state, updated in the decode cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_req_q <= '0;
			new_addr_q <= '0;
			bus_addr_q <= '0;
			cur_cfg_q  <= '0;
		end else if (do_decode) begin
			case (cmd_q)
				CMD_SETUP: begin
					last_req_q <= rc_q;
					if (dec.set_addr) new_addr_q <= vl_q;
					if (dec.set_cfg) cur_cfg_q <= vl_q;
				end
				CMD_IN_DONE: begin
					// address takes effect after the status stage
					if (last_req_q == REQ_SET_DEV_ADDR) bus_addr_q <= new_addr_q[6:0];
				end
				CMD_BUS_RST: begin
					bus_addr_q <= '0;
					cur_cfg_q  <= '0;
				end
				default: cur_cfg_q <= cur_cfg_q;
			endcase
		end
	end

	// emit context per event kind
	always_comb begin
		hs_d   = HS_IDLE;
		len_d  = '0;
		ein_d  = 1'b0;
		eout_d = 1'b0;
		erst_d = 1'b0;
		case (cmd_q)
			CMD_SETUP: begin
				if (dec.err) begin
					hs_d = HS_STALL;
				end else begin
					hs_d   = HS_ACK;
					ein_d  = dec.ein;
					eout_d = dec.eout;
					// host-to-device requests get a status stage only
					len_d  = rt_q[7] ? clip_len : 7'd0;
				end
			end
			CMD_BUS_RST: erst_d = 1'b1;
			default:     erst_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_decode) begin
			idx_q  <= '0;
			src_q  <= dec.src;
			hs_q   <= hs_d;
			len_q  <= len_d;
			ein_q  <= ein_d;
			eout_q <= eout_d;
			erst_q <= erst_d;
		end else if (load) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hs_out_q   <= hs_q;
			txl_out_q  <= len_q;
			bv_out_q   <= (len_q != 7'd0);
			byte_out_q <= (len_q != 7'd0) ? rom_byte : 8'h00;
			last_out_q <= final_beat;
			addr_out_q <= bus_addr_q;
			cfg_out_q  <= cur_cfg_q;
			ein_out_q  <= ein_q;
			eout_out_q <= eout_q;
			erst_out_q <= erst_q;
		end
	end

	assign res_valid          = res_valid_q;
	assign handshake          = hs_out_q;
	assign tx_length          = txl_out_q;
	assign data_byte          = byte_out_q;
	assign byte_valid         = bv_out_q;
	assign last               = last_out_q;
	assign device_address     = addr_out_q;
	assign configuration      = cfg_out_q;
	assign ep1_in_halt_clear  = ein_out_q;
	assign ep1_out_halt_clear = eout_out_q;
	assign ep1_reset          = erst_out_q;

endmodule
`default_nettype wire

>>> design/ucep_chk.sv
// ucep_chk: port-level checker of the control endpoint handler, bound
// to usb_control_endpoint_handler_unit. Uses ucep_pkg.
`default_nettype none
module ucep_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] handshake,
	input wire logic [6:0] tx_length,
	input wire logic [7:0] data_byte,
	input wire logic       byte_valid,
	input wire logic       last
);
	import ucep_pkg::*;

	// a taken event closes the input side in the cycle after it
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("event taken while previous one still in decode");

	// data stage bytes follow back to back once the sink takes one
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last |=> res_valid)
		else $error("gap inside data stage");

	// data bytes are always acked with a nonzero length
	a_data_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_valid |-> handshake == HS_ACK && tx_length != 7'd0)
		else $error("data beat with bad handshake or length");

	// non-data results are single, closing beats with no payload
	a_ctrl_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !byte_valid |-> last && tx_length == 7'd0 && data_byte == 8'h00)
		else $error("control result malformed");

endmodule

bind usb_control_endpoint_handler_unit ucep_chk u_ucep_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.handshake  (handshake),
	.tx_length  (tx_length),
	.data_byte  (data_byte),
	.byte_valid (byte_valid),
	.last       (last)
);
`default_nettype wire
